// ===== rtl/spq_pkg.sv =====
`default_nettype none

package spq_pkg;

  localparam int unsigned DATA_W  = 32;
  localparam int unsigned REQ_W   = 2;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned COUNT_W = 5;

  localparam logic signed [DATA_W-1:0] EMPTY_ITEM = -32'sd1;

  typedef enum logic [REQ_W-1:0] {
    REQ_ENQ  = 2'd0,
    REQ_DEQ  = 2'd1,
    REQ_PEEK = 2'd2,
    REQ_NOP  = 2'd3
  } req_e_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e_t;

  typedef enum logic {
    S_IDLE,
    S_HOLD
  } state_t;

  // commands from the controller to the slot chain
  typedef struct packed {
    logic   load;
    req_e_t op;
    logic   enq;
    logic   deq;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } flags_t;

endpackage

`default_nettype wire

// ===== rtl/spq_if.sv =====
`default_nettype none

interface spq_req_if;
  logic                                     valid;
  logic                                     ready;
  logic [spq_pkg::REQ_W-1:0]                req_type;
  logic signed [spq_pkg::DATA_W-1:0]        new_item;
  logic signed [spq_pkg::DATA_W-1:0]        new_priority;

  modport source (output valid, output req_type, output new_item, output new_priority,
                  input ready);
  modport sink (input valid, input req_type, input new_item, input new_priority,
                output ready);
endinterface

interface spq_res_if;
  logic                                     valid;
  logic                                     ready;
  logic [spq_pkg::STAT_W-1:0]               status;
  logic signed [spq_pkg::DATA_W-1:0]        out_item;
  logic signed [spq_pkg::DATA_W-1:0]        out_priority;
  logic [spq_pkg::COUNT_W-1:0]              entry_count;

  modport source (output valid, output status, output out_item, output out_priority,
                  output entry_count, input ready);
  modport sink (input valid, input status, input out_item, input out_priority,
                input entry_count, output ready);
endinterface

`default_nettype wire

// ===== rtl/spq_ctrl.sv =====
`default_nettype none

module spq_ctrl (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      req_valid,
  input  wire logic [spq_pkg::REQ_W-1:0] req_type,
  output logic                           req_ready,
  output logic                           res_valid,
  input  wire logic                      res_ready,
  input  wire spq_pkg::flags_t           flags,
  output spq_pkg::cmd_t                  cmd
);

  spq_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= spq_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    res_valid  = 1'b0;
    req_ready  = 1'b0;
    case (state)
      spq_pkg::S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          state_next = spq_pkg::S_HOLD;
        end
      end
      spq_pkg::S_HOLD: begin
        res_valid = 1'b1;
        // the result register is reloaded in the cycle it is taken
        req_ready = res_ready;
        if (res_ready && !req_valid) begin
          state_next = spq_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = spq_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd.load = req_valid && req_ready;
    cmd.op   = spq_pkg::req_e_t'(req_type);
    cmd.enq  = cmd.load && (cmd.op == spq_pkg::REQ_ENQ) && !flags.full;
    cmd.deq  = cmd.load && (cmd.op == spq_pkg::REQ_DEQ) && !flags.empty;
  end

  a_hold_until_taken: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ready) |=> res_valid)
    else $error("result dropped before it was taken");

endmodule

`default_nettype wire

// ===== rtl/spq_datapath.sv =====
`default_nettype none

module spq_datapath #(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire spq_pkg::cmd_t                       cmd,
  input  wire logic signed [spq_pkg::DATA_W-1:0]   new_item,
  input  wire logic signed [spq_pkg::DATA_W-1:0]   new_priority,
  output spq_pkg::flags_t                          flags,
  output logic [spq_pkg::STAT_W-1:0]               status,
  output logic signed [spq_pkg::DATA_W-1:0]        out_item,
  output logic signed [spq_pkg::DATA_W-1:0]        out_priority,
  output logic [spq_pkg::COUNT_W-1:0]              entry_count
);

  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic signed [spq_pkg::DATA_W-1:0] slot_item     [DEPTH];
  logic signed [spq_pkg::DATA_W-1:0] slot_priority [DEPTH];
  logic [CW-1:0]                     count, count_next;
  logic                              head_wins;
  // at_or_after[k]: the insertion point lies at or below cell k
  logic [DEPTH-1:0]                  at_or_after;

  assign flags.empty = (count == '0);
  assign flags.full  = (count == CW'(DEPTH));

  assign head_wins = flags.empty || (new_priority > slot_priority[0]);

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    if (k == 0) begin : g_head
      assign at_or_after[k] = head_wins;
      always_ff @(posedge clk) begin
        if (cmd.enq && at_or_after[k]) begin
          slot_item[k]     <= new_item;
          slot_priority[k] <= new_priority;
        end else if (cmd.deq) begin
          slot_item[k]     <= slot_item[k+1];
          slot_priority[k] <= slot_priority[k+1];
        end
      end
    end else begin : g_body
      // list is sorted, so the compare results form one run from the insertion point to the tail
      assign at_or_after[k] = head_wins || (CW'(k) >= count) ||
                              (slot_priority[k] <= new_priority);
      always_ff @(posedge clk) begin
        if (cmd.enq) begin
          if (at_or_after[k-1]) begin
            slot_item[k]     <= slot_item[k-1];
            slot_priority[k] <= slot_priority[k-1];
          end else if (at_or_after[k]) begin
            slot_item[k]     <= new_item;
            slot_priority[k] <= new_priority;
          end
        end else if (cmd.deq && (k < DEPTH - 1)) begin
          slot_item[k]     <= slot_item[(k < DEPTH - 1) ? k + 1 : k];
          slot_priority[k] <= slot_priority[(k < DEPTH - 1) ? k + 1 : k];
        end
      end
    end
  end

  always_comb begin
    count_next = count;
    if (cmd.enq) begin
      count_next = count + CW'(1);
    end else if (cmd.deq) begin
      count_next = count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      entry_count  <= spq_pkg::COUNT_W'(count_next);
      status       <= spq_pkg::ST_OK;
      out_item     <= '0;
      out_priority <= '0;
      case (cmd.op)
        spq_pkg::REQ_ENQ: begin
          if (flags.full) begin
            status <= spq_pkg::ST_FULL;
          end
        end
        spq_pkg::REQ_DEQ: begin
          if (flags.empty) begin
            status   <= spq_pkg::ST_EMPTY;
            out_item <= spq_pkg::EMPTY_ITEM;
          end else begin
            out_item     <= slot_item[0];
            out_priority <= slot_priority[0];
          end
        end
        spq_pkg::REQ_PEEK: begin
          if (flags.empty) begin
            status   <= spq_pkg::ST_EMPTY;
            out_item <= spq_pkg::EMPTY_ITEM;
          end else begin
            out_item <= slot_item[0];
          end
        end
        default: begin
        end
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("entry count beyond depth");

  a_no_enq_when_full: assert property (@(posedge clk) disable iff (rst)
    cmd.enq |-> !flags.full)
    else $error("insert issued into a full chain");

  a_deq_shrinks: assert property (@(posedge clk) disable iff (rst)
    cmd.deq |=> (count == CW'($past(count) - CW'(1))))
    else $error("removal did not shrink the count");

  a_head_sorted: assert property (@(posedge clk) disable iff (rst)
    (count >= CW'(2)) |-> (slot_priority[0] >= slot_priority[1]))
    else $error("head priority below second entry");

endmodule

`default_nettype wire

// ===== rtl/sorted_priority_queue.sv =====
// Sorted priority queue of up to DEPTH (item, priority) entries, highest priority at
// the head, kept in a chain of slot registers in which every slot compares its own
// priority with the incoming one and shifts in the cycle a request is accepted. A
// request accepted at a clock edge has its result in the output register from the
// next cycle; a new request is taken in the same cycle that the waiting result is
// taken, so with the result side always ready the block handles one item per clock,
// and otherwise one item per result handshake. Ties with the head go right after it.
// Slot contents need no clearing after reset; only the fill count and controller state are reset.
`default_nettype none

module sorted_priority_queue #(
  parameter int unsigned DEPTH = 16
) (
  input wire logic  clk,
  input wire logic  rst,
  spq_req_if.sink   req,
  spq_res_if.source res
);

  spq_pkg::cmd_t   cmd;
  spq_pkg::flags_t flags;

  spq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_type  (req.req_type),
    .req_ready (req.ready),
    .res_valid (res.valid),
    .res_ready (res.ready),
    .flags     (flags),
    .cmd       (cmd)
  );

  spq_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .new_item     (req.new_item),
    .new_priority (req.new_priority),
    .flags        (flags),
    .status       (res.status),
    .out_item     (res.out_item),
    .out_priority (res.out_priority),
    .entry_count  (res.entry_count)
  );

endmodule

`default_nettype wire
